>>> hw/rtl/gcd_pkg.sv
// Shared types, constants and arithmetic helpers for the great-circle distance unit.
// No dependencies; imported by every module of the block.
package gcd_pkg;

  // Width of the Q30 datapath (sines, cosines, angles in radians)
  localparam int QW = 34;

  // Angle input scaling and the derived degree constants
  localparam int                 ANGLE_FRAC_BITS = 20;
  localparam logic signed [29:0] FULL_DEG        = 30'sd377487360;
  localparam logic signed [29:0] HALF_DEG        = 30'sd188743680;
  localparam logic signed [29:0] QUARTER_DEG     = 30'sd94371840;

  // Degree-to-radian conversion: half turn is 45 * 2^22
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [58:0] DEG_ROUND   = 59'd94371840;
  localparam logic [31:0] RECIP_45    = 32'd3054198966;
  localparam logic [8:0]  DIV_CONST   = 9'd45;

  localparam logic signed [QW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [QW:0]   PI_EXT   = 35'sd3373259426;

  localparam logic [23:0] RADIUS_RESET = 24'd12777701;
  localparam logic [24:0] DIST_MAX     = 25'd26353587;

  // Queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Angle after periodic reduction and fold into [-90, 90] degrees
  typedef struct packed {
    logic        neg;
    logic        sgn;
    logic [26:0] mag;
  } red_t;

  // One queued item: three angles in Q30 radians and their fold flags
  typedef struct packed {
    logic [2:0]         neg;
    logic [2:0][QW-1:0] z;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return $signed({2'b00, v});
  endfunction

  // Q30 product, floor
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[QW+29:30];
  endfunction

  // Reduce to [-180, 180) degrees, then fold into [-90, 90]
  function automatic red_t reduce_angle(input logic signed [29:0] d);
    logic signed [29:0] r;
    logic signed [29:0] f;
    logic signed [29:0] m;
    red_t               res;
    res.neg = 1'b0;
    if (d >= HALF_DEG) begin
      r = d - FULL_DEG;
    end else if (d < -HALF_DEG) begin
      r = d + FULL_DEG;
    end else begin
      r = d;
    end
    f = r;
    if (r > QUARTER_DEG) begin
      f       = r - HALF_DEG;
      res.neg = 1'b1;
    end else if (r < -QUARTER_DEG) begin
      f       = r + HALF_DEG;
      res.neg = 1'b1;
    end
    res.sgn = f[29];
    m       = f[29] ? -f : f;
    res.mag = m[26:0];
    return res;
  endfunction

endpackage

>>> hw/rtl/gcd_cordic.sv
// Pipelined CORDIC, one register stage per iteration, rotation or vectoring mode.
// Depends on gcd_pkg for the atan table and datapath width.
module gcd_cordic import gcd_pkg::*; #(
  parameter int STAGES = 24,
  parameter bit VECT   = 1'b0,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [QW-1:0] x_i,
  input  logic signed [QW-1:0] y_i,
  input  logic signed [QW-1:0] z_i,
  input  logic [SW-1:0]        side_i,
  output logic signed [QW-1:0] x_o,
  output logic signed [QW-1:0] y_o,
  output logic signed [QW-1:0] z_o,
  output logic [SW-1:0]        side_o
);

  logic signed [QW-1:0] x_r [STAGES];
  logic signed [QW-1:0] y_r [STAGES];
  logic signed [QW-1:0] z_r [STAGES];
  logic [SW-1:0]        side_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [QW-1:0] xin, yin, zin, at;
    logic [SW-1:0]        sd_in;
    logic                 up;

    if (g == 0) begin : g_first
      assign xin   = x_i;
      assign yin   = y_i;
      assign zin   = z_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign xin   = x_r[g-1];
      assign yin   = y_r[g-1];
      assign zin   = z_r[g-1];
      assign sd_in = side_r[g-1];
    end

    assign at = atan_q30(5'(g));
    // Rotate towards zero residual angle, or towards the x axis
    assign up = VECT ? !(yin > 0) : (zin >= 0);

    // Advance one micro-rotation
    always_ff @(posedge clk) begin
      if (en) begin
        if (up) begin
          x_r[g] <= xin - (yin >>> g);
          y_r[g] <= yin + (xin >>> g);
          z_r[g] <= zin - at;
        end else begin
          x_r[g] <= xin + (yin >>> g);
          y_r[g] <= yin - (xin >>> g);
          z_r[g] <= zin + at;
        end
        side_r[g] <= sd_in;
      end
    end
  end

  assign x_o    = x_r[STAGES-1];
  assign y_o    = y_r[STAGES-1];
  assign z_o    = z_r[STAGES-1];
  assign side_o = side_r[STAGES-1];

endmodule

>>> hw/rtl/gcd_front.sv
// Front end: accepts point pairs, reduces the three angles and converts them to Q30 radians.
// Depends on gcd_pkg; feeds gcd_queue.
module gcd_front import gcd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  input  logic               q_full,
  output logic               push,
  output q_item_t            item
);

  logic [3:0]  v_r;
  logic        adv;
  logic signed [29:0] deg [3];

  red_t        red_r [3];
  logic [58:0] prod_r [3];
  logic [1:0]  flg2_r [3];
  logic [31:0] e_r [3];
  logic [8:0]  xl_r [3];
  logic [1:0]  flg3_r [3];
  q_item_t     item_r;

  // Hold the whole front while its last stage cannot enter the queue
  assign adv      = !(v_r[3] && q_full);
  assign in_stall = !adv;
  assign push     = v_r[3] && adv;
  assign item     = item_r;

  assign deg[0] = 30'(lat_a);
  assign deg[1] = 30'(lat_b);
  assign deg[2] = 30'(lon_b) - 30'(lon_a);

  // Valid per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Reduce, scale by pi/180, divide by 45 via reciprocal, correct, restore sign
  always_ff @(posedge clk) begin
    logic [36:0] xq;
    logic [63:0] ep;
    logic [8:0]  rem;
    logic [8:0]  e45;
    logic [31:0] zm;
    logic [QW-1:0] zx;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        red_r[a]  <= reduce_angle(deg[a]);
        prod_r[a] <= 59'(red_r[a].mag) * 59'(PI_Q30) + DEG_ROUND;
        flg2_r[a] <= {red_r[a].neg, red_r[a].sgn};

        xq        = prod_r[a][58:22];
        ep        = 64'(xq[36:5]) * 64'(RECIP_45);
        e_r[a]    <= ep[63:32];
        xl_r[a]   <= xq[8:0];
        flg3_r[a] <= flg2_r[a];

        e45 = e_r[a][8:0] * DIV_CONST;
        rem = xl_r[a] - e45;
        if (rem >= 9'd90) begin
          zm = e_r[a] + 32'd2;
        end else if (rem >= DIV_CONST) begin
          zm = e_r[a] + 32'd1;
        end else begin
          zm = e_r[a];
        end
        zx = {2'b00, zm};
        item_r.z[a]   <= flg3_r[a][0] ? -zx : zx;
        item_r.neg[a] <= flg3_r[a][1];
      end
    end
  end

endmodule

>>> hw/rtl/gcd_queue.sv
// Short FIFO between the front and the back so each side can stall on its own.
// Depends on gcd_pkg for the item type and depth.
module gcd_queue import gcd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  input  logic    pop,
  output q_item_t head,
  output q_stat_t stat
);

  q_item_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_r, rd_r;
  logic [QUEUE_AW:0]    cnt_r;

  assign head       = mem_r[rd_r];
  assign stat.full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end
  end

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/gcd_back.sv
// Back end: sine/cosine, spherical terms, magnitude and atan2 CORDICs, radius scaling.
// Depends on gcd_pkg and gcd_cordic; drains gcd_queue.
module gcd_back import gcd_pkg::*; #(
  parameter int STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_item_t     head,
  input  logic        q_empty,
  output logic        pop,
  input  logic [23:0] radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] distance_m
);

  localparam int LAT = 3 * STAGES + 8;

  logic [LAT-1:0] vld_r;
  logic           ben;

  logic signed [QW-1:0] rx [3];
  logic signed [QW-1:0] ry [3];
  logic                 rneg [3];
  logic signed [QW-1:0] s_r [3];
  logic signed [QW-1:0] c_r [3];

  logic signed [QW-1:0] y1_r, t1_r, p_r, cc_r, u_r, cd_r;
  logic signed [QW-1:0] y1b_r, y2_r, den_r;
  logic signed [QW-1:0] vx_r, vy_r, den2_r;
  logic signed [QW-1:0] mx;
  logic [QW-1:0]        den3;
  logic signed [QW-1:0] num_r, den4_r;
  logic signed [QW-1:0] ax_r, ay_r;
  logic                 dneg_r;
  logic signed [QW-1:0] ang;
  logic                 dneg2;
  logic [31:0]          theta_r;
  logic [24:0]          dist_r;

  // Freeze the back while a finished result waits
  assign ben        = !(out_valid && out_stall);
  assign pop        = ben && !q_empty;
  assign out_valid  = vld_r[LAT-1];
  assign distance_m = dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ben) begin
      vld_r <= {vld_r[LAT-2:0], pop};
    end
  end

  // Sine and cosine of both latitudes and the longitude difference
  for (genvar a = 0; a < 3; a++) begin : g_rot
    gcd_cordic #(.STAGES(STAGES), .VECT(1'b0), .SW(1)) u_rot (
      .clk    (clk),
      .en     (ben),
      .x_i    (GAIN_Q30),
      .y_i    ('0),
      .z_i    ($signed(head.z[a])),
      .side_i (head.neg[a]),
      .x_o    (rx[a]),
      .y_o    (ry[a]),
      .z_o    (),
      .side_o (rneg[a])
    );
  end

  // Undo the fold, form the spherical terms
  always_ff @(posedge clk) begin
    if (ben) begin
      for (int a = 0; a < 3; a++) begin
        s_r[a] <= rneg[a] ? -ry[a] : ry[a];
        c_r[a] <= rneg[a] ? -rx[a] : rx[a];
      end
      y1_r <= mulq(c_r[1], s_r[2]);
      t1_r <= mulq(c_r[0], s_r[1]);
      p_r  <= mulq(s_r[0], c_r[1]);
      cc_r <= mulq(c_r[0], c_r[1]);
      u_r  <= mulq(s_r[0], s_r[1]);
      cd_r <= c_r[2];

      y1b_r <= y1_r;
      y2_r  <= t1_r - mulq(p_r, cd_r);
      den_r <= u_r + mulq(cc_r, cd_r);

      vx_r   <= y1b_r[QW-1] ? -y1b_r : y1b_r;
      vy_r   <= y2_r[QW-1] ? -y2_r : y2_r;
      den2_r <= den_r;
    end
  end

  // Magnitude of the numerator vector
  gcd_cordic #(.STAGES(STAGES), .VECT(1'b1), .SW(QW)) u_mag (
    .clk    (clk),
    .en     (ben),
    .x_i    (vx_r),
    .y_i    (vy_r),
    .z_i    ('0),
    .side_i (den2_r),
    .x_o    (mx),
    .y_o    (),
    .z_o    (),
    .side_o (den3)
  );

  always_ff @(posedge clk) begin
    if (ben) begin
      num_r  <= mulq(mx, GAIN_Q30);
      den4_r <= $signed(den3);
      ax_r   <= den4_r[QW-1] ? -den4_r : den4_r;
      ay_r   <= num_r;
      dneg_r <= den4_r[QW-1];
    end
  end

  // Central angle
  gcd_cordic #(.STAGES(STAGES), .VECT(1'b1), .SW(1)) u_ang (
    .clk    (clk),
    .en     (ben),
    .x_i    (ax_r),
    .y_i    (ay_r),
    .z_i    ('0),
    .side_i (dneg_r),
    .x_o    (),
    .y_o    (),
    .z_o    (ang),
    .side_o (dneg2)
  );

  // Mirror for a negative denominator, clamp, scale by radius, round, saturate
  always_ff @(posedge clk) begin
    logic signed [QW:0] th;
    logic [56:0]        dp;
    logic [25:0]        dv;
    if (ben) begin
      th = dneg2 ? (PI_EXT - (QW+1)'(ang)) : (QW+1)'(ang);
      if (th[QW]) begin
        theta_r <= '0;
      end else if (th > PI_EXT) begin
        theta_r <= PI_Q30;
      end else begin
        theta_r <= th[31:0];
      end
      dp = 57'(theta_r) * 57'(radius) + (57'd1 << 30);
      dv = dp[56:31];
      dist_r <= (dv > 26'(DIST_MAX)) ? DIST_MAX : dv[24:0];
    end
  end

endmodule

>>> hw/rtl/great_circle_distance_unit.sv
// Top level of the great-circle distance unit: radius register, front, queue and back.
// Depends on gcd_pkg, gcd_front, gcd_queue and gcd_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  input    | in_valid / in_stall | lat_a, lon_a, lat_b, lon_b
//  result   | out_valid/out_stall | distance_m
//  config   | cfg_we              | cfg_wdata (sphere radius, half metres)
//
// One point pair per clock sustained while the result is not stalled; the path runs
// through 4 front stages, the queue, three pipelined CORDICs and 8 further back stages.
// Synchronous active-low reset empties the pipeline and queue, radius returns
// to its reset value. A stalled result freezes the back; the front keeps taking
// pairs until the 4-entry queue is full.
module great_circle_distance_unit import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [24:0]        distance_m,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata
);

  logic [23:0] radius_r;
  logic        push, pop;
  q_item_t     fr_item, q_head;
  q_stat_t     q_stat;

  // Radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  gcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .lat_a    (lat_a),
    .lon_a    (lon_a),
    .lat_b    (lat_b),
    .lon_b    (lon_b),
    .q_full   (q_stat.full),
    .push     (push),
    .item     (fr_item)
  );

  gcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fr_item),
    .pop   (pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  gcd_back #(.STAGES(CORDIC_STAGES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_stat.empty),
    .pop        (pop),
    .radius     (radius_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .distance_m (distance_m)
  );

`ifndef NO_ASSERTIONS
  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("push into full queue");

  // Never read from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("pop from empty queue");

  // Input stall only arises from back-pressure through the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_stat.full) else $error("input stalled with queue room");

  // A frozen back does not drain the queue
  a_hold_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !pop) else $error("pop while result stalled");
`endif

endmodule

>>> tb/sv/great_circle_distance_unit_test.sv
// Testbench for great_circle_distance_unit: directed and random point pairs,
// checked against a predictor of the fixed-point CORDIC distance. Uses gcd_pkg.
`timescale 1ns / 100ps

module great_circle_distance_unit_test;
  import gcd_pkg::*;

  localparam int      STAGES      = 24;
  localparam int      DRAIN_WAIT  = 3 * STAGES + 40;
  localparam int      CYCLE_LIMIT = 600000;
  localparam longint  PI_FIX      = 64'sd3373259426;
  localparam longint  GAIN_FIX    = 64'sd652032874;
  localparam longint  LAT_MAX     = 64'sd94371840;
  localparam longint  LON_MAX     = 64'sd188743680;

  typedef struct {
    logic signed [27:0] lat_a;
    logic signed [28:0] lon_a;
    logic signed [27:0] lat_b;
    logic signed [28:0] lon_b;
  } point_pair_t;

  // Directed row; known_m < 0 means the predictor alone decides
  typedef struct {
    point_pair_t pair;
    longint      known_m;
  } pair_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [27:0] lat_a;
  logic signed [28:0] lon_a;
  logic signed [27:0] lat_b;
  logic signed [28:0] lon_b;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [24:0]        distance_m;
  logic               cfg_we;
  logic [23:0]        cfg_wdata;

  logic [23:0]        radius_half_m;
  logic [24:0]        pending_dist_q[$];
  int                 mismatch_count;
  int                 send_idle_pct;
  int                 stall_pct;
  int                 hold_off_len;
  int                 hold_off_cnt = 0;
  int                 cycle_count = 0;

  great_circle_distance_unit #(.CORDIC_STAGES(STAGES)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance_m(distance_m),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint atan_step(int i);
    longint steps[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};
    return steps[i];
  endfunction

  // Reduce to a half turn either side, fold into a quarter turn, rotate
  task automatic deg_sin_cos(input longint deg, output longint s, output longint c);
    longint full_turn, half_turn, quarter_turn, r, m, x, y, z, nx;
    bit     folded;
    full_turn    = longint'(360) << 20;
    half_turn    = longint'(180) << 20;
    quarter_turn = longint'(90) << 20;
    folded       = 1'b0;
    r = deg % full_turn;
    if (r < 0) r += full_turn;
    if (r >= half_turn) r -= full_turn;
    if (r > quarter_turn) begin
      r -= half_turn;
      folded = 1'b1;
    end else if (r < -quarter_turn) begin
      r += half_turn;
      folded = 1'b1;
    end
    m = (r < 0) ? -r : r;
    z = (m * PI_FIX + half_turn / 2) / half_turn;
    if (r < 0) z = -z;
    x = GAIN_FIX;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z -= atan_step(i);
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z += atan_step(i);
      end
      x = nx;
    end
    c = folded ? -x : x;
    s = folded ? -y : y;
  endtask

  task automatic vector_rotate(input longint xi, input longint yi,
                               output longint mag, output longint ang);
    longint x, y, z, nx;
    x = xi;
    y = yi;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z += atan_step(i);
      end else begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z -= atan_step(i);
      end
      x = nx;
    end
    mag = qmul(x, GAIN_FIX);
    ang = z;
  endtask

  // Central angle by the atan2 form, then scale by the radius
  task automatic predict_distance(input point_pair_t p, input logic [23:0] radius,
                                  output logic [24:0] want_m);
    longint s1, c1, s2, c2, sd, cd, y1, y2, den, num, theta, unused, d;
    deg_sin_cos(longint'(p.lat_a), s1, c1);
    deg_sin_cos(longint'(p.lat_b), s2, c2);
    deg_sin_cos(longint'(p.lon_b) - longint'(p.lon_a), sd, cd);
    y1  = qmul(c2, sd);
    y2  = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
    den = qmul(s1, s2) + qmul(qmul(c1, c2), cd);
    if (y1 < 0) y1 = -y1;
    if (y2 < 0) y2 = -y2;
    if (y1 == 0 && y2 == 0) num = 0;
    else vector_rotate(y1, y2, num, unused);
    if (den == 0 && num == 0) begin
      theta = 0;
    end else begin
      vector_rotate((den < 0) ? -den : den, num, unused, theta);
      if (den < 0) theta = PI_FIX - theta;
    end
    if (theta < 0) theta = 0;
    if (theta > PI_FIX) theta = PI_FIX;
    d = (theta * longint'(radius) + (longint'(1) << 30)) >>> 31;
    if (d > longint'(DIST_MAX)) d = longint'(DIST_MAX);
    want_m = d[24:0];
  endtask

  function automatic longint pick_signed(longint lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Mostly in range, some raw bit patterns, some coincident or mirrored points
  function automatic point_pair_t random_pair();
    point_pair_t p;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      p.lat_a = 28'(pick_signed(LAT_MAX));
      p.lon_a = 29'(pick_signed(LON_MAX));
      p.lat_b = 28'(pick_signed(LAT_MAX));
      p.lon_b = 29'(pick_signed(LON_MAX));
    end else if (mode < 8) begin
      p.lat_a = 28'($urandom());
      p.lon_a = 29'($urandom());
      p.lat_b = 28'($urandom());
      p.lon_b = 29'($urandom());
    end else begin
      p.lat_a = 28'(pick_signed(LAT_MAX));
      p.lon_a = 29'(pick_signed(LON_MAX));
      p.lat_b = (mode == 8) ? p.lat_a : -p.lat_a;
      p.lon_b = (mode == 8) ? 29'(longint'(p.lon_a) + pick_signed(64))
                            : 29'(longint'(p.lon_a) + LON_MAX);
    end
    return p;
  endfunction

  task automatic send_pair(input point_pair_t p, input longint known_m);
    logic [24:0] want_m;
    in_valid <= 1'b1;
    lat_a    <= p.lat_a;
    lon_a    <= p.lon_a;
    lat_b    <= p.lat_b;
    lon_b    <= p.lon_b;
    do @(posedge clk); while (in_stall);
    predict_distance(p, radius_half_m, want_m);
    if (known_m >= 0 && longint'(want_m) != known_m) begin
      $error("distance_m predictor: expected %0d, actual %0d", known_m, want_m);
      mismatch_count++;
    end
    pending_dist_q.push_back(want_m);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_radius(input logic [23:0] r);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we        <= 1'b0;
    radius_half_m  = r;
  endtask

  // Receiver: random stall, or a long hold-off once its length is set
  always @(posedge clk) begin
    if (hold_off_cnt < hold_off_len) begin
      hold_off_cnt <= hold_off_cnt + 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dist_q.size() == 0) begin
        $error("distance_m: no transfer expected, actual %0d", distance_m);
        mismatch_count++;
      end else begin
        if (distance_m !== pending_dist_q[0]) begin
          $error("distance_m: expected %0d, actual %0d", pending_dist_q[0], distance_m);
          mismatch_count++;
        end
        void'(pending_dist_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    pair_row_t   rows[$];
    point_pair_t p;
    logic [23:0] radii[4];
    int          idle_set[4][2];

    rst_n = 1'b0; in_valid = 1'b0; cfg_we = 1'b0;
    cfg_wdata = '0; lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
    radius_half_m = RADIUS_RESET; mismatch_count = 0;
    send_idle_pct = 0; stall_pct = 0; hold_off_len = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: poles, dateline, range edges, raw extremes, coincident points
    rows = '{
      '{'{28'sd0, 29'sd0, 28'sd0, 29'sd0}, -1},
      '{'{28'sd94371840, 29'sd0, -28'sd94371840, 29'sd0}, -1},
      '{'{28'sd94371840, 29'sd0, 28'sd94371840, 29'sd188743680}, -1},
      '{'{28'sd0, -29'sd188743680, 28'sd0, 29'sd188743680}, -1},
      '{'{28'sd0, 29'sd0, 28'sd0, 29'sd188743680}, -1},
      '{'{28'sd0, 29'sd0, 28'sd0, -29'sd188743680}, -1},
      '{'{28'sd0, 29'sd0, 28'sd0, 29'sd94371840}, -1},
      '{'{28'sd0, 29'sd188743679, 28'sd0, -29'sd188743679}, -1},
      '{'{28'sh8000000, 29'sh10000000, 28'sd134217727, 29'sd268435455}, -1},
      '{'{28'sd134217727, 29'sd268435455, 28'sd134217727, 29'sd268435455}, -1},
      '{'{28'sh8000000, 29'sd268435455, -28'sd94371840, 29'sh10000000}, -1},
      '{'{28'sd53477376, 29'sd1048576, 28'sd53477376, 29'sd1048577}, -1},
      '{'{28'sd1, 29'sd1, -28'sd1, -29'sd1}, -1},
      '{'{28'sd31457280, 29'sd12345678, -28'sd31457280, -29'sd176398002}, -1},
      '{'{28'sd100000000, 29'sd200000000, -28'sd100000000, -29'sd10000000}, -1}
    };
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known_m);

    radii = '{24'd16777215, 24'd1, 24'($urandom_range(2, 16777214)), 24'd12756274};
    idle_set = '{'{0, 0}, '{68, 0}, '{0, 68}, '{20, 20}};

    // Phases of idling, each under its own radius
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) write_radius(radii[ph]);
      else write_radius(24'($urandom_range(1, 16777215)));
      send_idle_pct = idle_set[ph % 4][0];
      stall_pct     = idle_set[ph % 4][1];
      if (ph == 4) hold_off_len = 400;
      for (int n = 0; n < 200; n++) begin
        p = random_pair();
        send_pair(p, -1);
        // Pause the sender once until everything has come back
        if (ph == 1 && n == 100) begin
          in_valid <= 1'b0;
          while (pending_dist_q.size() != 0) @(posedge clk);
        end
      end
    end

    stall_pct = 0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
